[src/olids_pkg.sv]
package olids_pkg;

  // Request actions
  typedef enum logic [1:0] {
    ACT_INSERT = 2'd0,
    ACT_DELETE = 2'd1,
    ACT_GET    = 2'd2,
    ACT_LOCATE = 2'd3
  } olids_act_t;

  // Result status codes
  typedef enum logic [1:0] {
    ST_DONE  = 2'd0,
    ST_RANGE = 2'd1,
    ST_FULL  = 2'd2
  } olids_status_t;

  // Sequencer states
  typedef enum logic [3:0] {
    S_IDLE,
    S_CHECK,
    S_INS,
    S_PUT,
    S_DEL,
    S_GET,
    S_GETW,
    S_LOC,
    S_DONE
  } olids_state_t;

  // Finished result handed from the sequencer to the output register
  typedef struct packed {
    logic               valid;
    olids_status_t      status;
    logic signed [31:0] value_out;
    logic [4:0]         found_position;
    logic [4:0]         count_out;
  } olids_res_t;

  localparam int unsigned DATA_W = 32;
  localparam int unsigned FIELD_W = 5;
  localparam logic [FIELD_W-1:0] LIMIT_RESET = 5'd10;

endpackage

[src/olids_store.sv]
module olids_store import olids_pkg::*; #(
  parameter int DEPTH = 16
) (
  input  logic                       clk,
  input  logic                       wr_en,
  input  logic [$clog2(DEPTH)-1:0]   wr_addr,
  input  logic signed [DATA_W-1:0]   wr_data,
  input  logic                       rd_en,
  input  logic [$clog2(DEPTH)-1:0]   rd_addr,
  output logic signed [DATA_W-1:0]   rd_data
);

  logic signed [DATA_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

[src/olids_seq.sv]
module olids_seq import olids_pkg::*; #(
  parameter int DEPTH = 16
) (
  input  logic                       clk,
  input  logic                       rst_n,
  // request
  input  logic                       req_valid,
  output logic                       req_stall,
  input  olids_act_t                 req_action,
  input  logic [FIELD_W-1:0]         req_position,
  input  logic signed [DATA_W-1:0]   req_value,
  input  logic [FIELD_W-1:0]         limit,
  // result
  output olids_res_t                 res,
  input  logic                       res_take,
  // store
  output logic                       wr_en,
  output logic [$clog2(DEPTH)-1:0]   wr_addr,
  output logic signed [DATA_W-1:0]   wr_data,
  output logic                       rd_en,
  output logic [$clog2(DEPTH)-1:0]   rd_addr,
  input  logic signed [DATA_W-1:0]   rd_data
);

  localparam int AW = $clog2(DEPTH);
  // count never exceeds the 5-bit limit nor the store depth
  localparam int CW = (DEPTH < 31) ? $clog2(DEPTH + 1) : FIELD_W;
  localparam logic [5:0] DEPTH_K = 6'((DEPTH > 32) ? 32 : DEPTH);

  olids_state_t             state_r, state_nxt;
  olids_act_t               act_r;
  logic [FIELD_W-1:0]       pos_r;
  logic signed [DATA_W-1:0] val_r;
  logic [CW-1:0]            cnt_r, cnt_nxt;
  logic [CW-1:0]            idx_r, idx_nxt;
  logic [CW-1:0]            tgt_r, tgt_nxt;
  logic                     pend_r, pend_nxt;
  logic                     first_r, first_nxt;
  olids_status_t            status_r, status_nxt;
  logic signed [DATA_W-1:0] vout_r, vout_nxt;
  logic [FIELD_W-1:0]       found_r, found_nxt;

  logic [5:0] pos6, cnt6, idx6, lim6, eff6;
  logic       ins_bad, ins_full, sel_bad, ins_more, scan_more, loc_hit, accept;

  assign pos6      = {1'b0, pos_r};
  assign cnt6      = 6'(cnt_r);
  assign idx6      = 6'(idx_r);
  assign lim6      = {1'b0, limit};
  assign eff6      = (lim6 > DEPTH_K) ? DEPTH_K : lim6;
  assign ins_bad   = (pos_r == '0) || (pos6 > cnt6 + 6'd1);
  assign ins_full  = cnt6 >= eff6;
  assign sel_bad   = (pos_r == '0) || (pos6 > cnt6);
  assign ins_more  = idx6 >= pos6;
  assign scan_more = idx_r < cnt_r;
  assign loc_hit   = pend_r && (rd_data == val_r);
  assign accept    = req_valid && !req_stall;

  assign req_stall = (state_r != S_IDLE);

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (req_valid) state_nxt = S_CHECK;
      end
      S_CHECK: begin
        case (act_r)
          ACT_INSERT: state_nxt = (ins_bad || ins_full) ? S_DONE : S_INS;
          ACT_DELETE: state_nxt = sel_bad ? S_DONE : S_DEL;
          ACT_GET:    state_nxt = sel_bad ? S_DONE : S_GET;
          default:    state_nxt = S_LOC;
        endcase
      end
      S_INS: begin
        if (!ins_more) state_nxt = S_PUT;
      end
      S_PUT:  state_nxt = S_DONE;
      S_DEL: begin
        if (!scan_more) state_nxt = S_DONE;
      end
      S_GET:  state_nxt = S_GETW;
      S_GETW: state_nxt = S_DONE;
      S_LOC: begin
        if (loc_hit || !scan_more) state_nxt = S_DONE;
      end
      S_DONE: begin
        if (res_take) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // datapath and store controls
  always_comb begin
    cnt_nxt    = cnt_r;
    idx_nxt    = idx_r;
    tgt_nxt    = tgt_r;
    pend_nxt   = 1'b0;
    first_nxt  = first_r;
    status_nxt = status_r;
    vout_nxt   = vout_r;
    found_nxt  = found_r;
    wr_en      = 1'b0;
    wr_addr    = AW'(tgt_r);
    wr_data    = rd_data;
    rd_en      = 1'b0;
    rd_addr    = AW'(idx_r);
    case (state_r)
      S_CHECK: begin
        status_nxt = ST_DONE;
        vout_nxt   = '0;
        found_nxt  = '0;
        first_nxt  = 1'b1;
        case (act_r)
          ACT_INSERT: begin
            if (ins_bad) status_nxt = ST_RANGE;
            else if (ins_full) status_nxt = ST_FULL;
            idx_nxt = cnt_r;
          end
          ACT_DELETE, ACT_GET: begin
            if (sel_bad) status_nxt = ST_RANGE;
            idx_nxt = CW'(pos6 - 6'd1);
          end
          default: idx_nxt = '0;
        endcase
      end
      S_INS: begin
        // commit the move read last cycle, fetch the next one down
        wr_en = pend_r;
        if (ins_more) begin
          rd_en    = 1'b1;
          rd_addr  = AW'(idx_r - CW'(1));
          pend_nxt = 1'b1;
          tgt_nxt  = idx_r;
          idx_nxt  = idx_r - CW'(1);
        end
      end
      S_PUT: begin
        wr_en   = 1'b1;
        wr_addr = AW'(pos6 - 6'd1);
        wr_data = val_r;
        cnt_nxt = cnt_r + CW'(1);
      end
      S_DEL: begin
        if (pend_r) begin
          if (first_r) begin
            vout_nxt  = rd_data;
            first_nxt = 1'b0;
          end else begin
            wr_en = 1'b1;
          end
        end
        if (scan_more) begin
          rd_en    = 1'b1;
          pend_nxt = 1'b1;
          tgt_nxt  = idx_r - CW'(1);
          idx_nxt  = idx_r + CW'(1);
        end else begin
          cnt_nxt = cnt_r - CW'(1);
        end
      end
      S_GET: begin
        rd_en = 1'b1;
      end
      S_GETW: begin
        vout_nxt = rd_data;
      end
      S_LOC: begin
        if (loc_hit) begin
          found_nxt = 5'(6'(tgt_r) + 6'd1);
        end else if (scan_more) begin
          rd_en    = 1'b1;
          pend_nxt = 1'b1;
          tgt_nxt  = idx_r;
          idx_nxt  = idx_r + CW'(1);
        end
      end
      default: ;
    endcase
  end

  always_comb begin
    res.valid          = (state_r == S_DONE);
    res.status         = status_r;
    res.value_out      = vout_r;
    res.found_position = found_r;
    res.count_out      = 5'(cnt_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r   <= '0;
      pend_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      pend_r  <= pend_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      act_r <= req_action;
      pos_r <= req_position;
      val_r <= req_value;
    end
    idx_r    <= idx_nxt;
    tgt_r    <= tgt_nxt;
    first_r  <= first_nxt;
    status_r <= status_nxt;
    vout_r   <= vout_nxt;
    found_r  <= found_nxt;
  end

endmodule

[src/ordered_list_insert_delete_search.sv]
// Channel  | ports                                            | direction
// ---------+--------------------------------------------------+----------
// in       | in_valid, in_stall, in_action, in_position,      | request
//          | in_value                                         |
// out      | out_valid, out_stall, out_status, out_value_out, | result
//          | out_found_position, out_count_out                |
// cfg      | cfg_we, cfg_wdata (capacity limit)               | write only
//
// One word at a time: the input stalls from one accept until the sequencer
// hands the result to the output register. A refused request or a get needs
// no walk; a delete, locate or insert walks entries one by one, so it lasts
// longer the more entries lie in its path. The shift or search walk goes over
// the store's single read port and single write port (one entry per cycle).
// Reset clears the entry count and loads the capacity limit with 10; the
// store itself holds garbage until written, and only written entries are read.
// A new word is taken while the previous result still waits in the output
// register; a stalled result holds the sequencer in its final state.
module ordered_list_insert_delete_search import olids_pkg::*; #(
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     rst_n,
  // request channel
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic [1:0]               in_action,
  input  logic [4:0]               in_position,
  input  logic signed [31:0]       in_value,
  // result channel
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic [1:0]               out_status,
  output logic signed [31:0]       out_value_out,
  output logic [4:0]               out_found_position,
  output logic [4:0]               out_count_out,
  // configuration
  input  logic                     cfg_we,
  input  logic [4:0]               cfg_wdata
);

  logic [FIELD_W-1:0]       limit_r;
  olids_res_t               res;
  logic                     res_take;

  logic                     wr_en, rd_en;
  logic [$clog2(DEPTH)-1:0] wr_addr, rd_addr;
  logic signed [DATA_W-1:0] wr_data, rd_data;

  logic                     out_valid_r;
  olids_status_t            out_status_r;
  logic signed [DATA_W-1:0] out_value_r;
  logic [FIELD_W-1:0]       out_found_r;
  logic [FIELD_W-1:0]       out_count_r;

  // capacity limit register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      limit_r <= LIMIT_RESET;
    end else if (cfg_we) begin
      limit_r <= cfg_wdata;
    end
  end

  olids_seq #(.DEPTH(DEPTH)) u_seq (
    .clk          (clk),
    .rst_n        (rst_n),
    .req_valid    (in_valid),
    .req_stall    (in_stall),
    .req_action   (olids_act_t'(in_action)),
    .req_position (in_position),
    .req_value    (in_value),
    .limit        (limit_r),
    .res          (res),
    .res_take     (res_take),
    .wr_en        (wr_en),
    .wr_addr      (wr_addr),
    .wr_data      (wr_data),
    .rd_en        (rd_en),
    .rd_addr      (rd_addr),
    .rd_data      (rd_data)
  );

  olids_store #(.DEPTH(DEPTH)) u_store (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // Output register: take a finished result whenever the slot is empty or
  // being drained this cycle.
  assign res_take = res.valid && (!out_valid_r || !out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_take) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  // hold payload while stalled; load only on a new result
  always_ff @(posedge clk) begin
    if (res_take) begin
      out_status_r <= res.status;
      out_value_r  <= res.value_out;
      out_found_r  <= res.found_position;
      out_count_r  <= res.count_out;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_status         = out_status_r;
  assign out_value_out      = out_value_r;
  assign out_found_position = out_found_r;
  assign out_count_out      = out_count_r;

endmodule

[test/ordered_list_insert_delete_search_tb.sv]
module ordered_list_insert_delete_search_tb;
  import olids_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int DEPTH = 16;
  // Settle time after the last result before touching the limit register,
  // and the tail wait at the end of the run: a full shift walk plus margin.
  localparam int SETTLE_CYCLES = DEPTH + 8;
  // Long receiver hold-offs start once this many words have gone in.
  localparam int HOLD_MARK_A = 300;
  localparam int HOLD_MARK_B = 900;
  localparam int HOLD_CYCLES = 250;
  localparam int PHASE_WORDS = 160;

  // One request word as queued for the driver.
  typedef struct packed {
    olids_act_t  act;
    logic [4:0]  pos;
    logic [31:0] val;
  } list_req_t;

  // One result word as the list should produce it.
  typedef struct packed {
    olids_status_t status;
    logic [31:0]   value_out;
    logic [4:0]    found_position;
    logic [4:0]    count_out;
  } list_result_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [1:0]  in_action = ACT_GET;
  logic [4:0]  in_position = '0;
  logic [31:0] in_value = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [1:0]  out_status;
  logic [31:0] out_value_out;
  logic [4:0]  out_found_position;
  logic [4:0]  out_count_out;
  logic        cfg_we = 1'b0;
  logic [4:0]  cfg_wdata = '0;

  ordered_list_insert_delete_search #(
    .DEPTH(DEPTH)
  ) i_dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_action         (in_action),
    .in_position       (in_position),
    .in_value          (in_value),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_status        (out_status),
    .out_value_out     (out_value_out),
    .out_found_position(out_found_position),
    .out_count_out     (out_count_out),
    .cfg_we            (cfg_we),
    .cfg_wdata         (cfg_wdata)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Shadow list: the expected contents, length and capacity limit. Only the
  // posedge monitor touches these.
  // ---------------------------------------------------------------------------
  logic [31:0] list_mem [DEPTH];
  int          list_len = 0;
  logic [4:0]  cap_reg = LIMIT_RESET;

  list_result_t expected_q [$];
  list_req_t    pending_q [$];

  int req_pushed = 0;   // words handed to the driver queue
  int req_offered = 0;  // words the driver has put on the bus
  int req_taken = 0;    // words the block has accepted
  int fault_count = 0;

  // Apply one accepted request to the shadow list and return its result.
  function automatic list_result_t apply_request(olids_act_t act, logic [4:0] pos,
                                                 logic [31:0] val);
    list_result_t r;
    int p;
    int lim;
    int j;
    r.status = ST_DONE;
    r.value_out = '0;
    r.found_position = '0;
    p = int'(pos);
    // limit saturates at the store depth
    lim = (cap_reg > DEPTH) ? DEPTH : int'(cap_reg);
    case (act)
      ACT_INSERT: begin
        // range check wins over the full check
        if (p < 1 || p > list_len + 1) begin
          r.status = ST_RANGE;
        end else if (list_len >= lim) begin
          r.status = ST_FULL;
        end else begin
          for (j = list_len; j >= p; j--) list_mem[j] = list_mem[j-1];
          list_mem[p-1] = val;
          list_len++;
        end
      end
      ACT_DELETE: begin
        if (p < 1 || p > list_len) begin
          r.status = ST_RANGE;
        end else begin
          r.value_out = list_mem[p-1];
          for (j = p; j < list_len; j++) list_mem[j-1] = list_mem[j];
          list_len--;
        end
      end
      ACT_GET: begin
        if (p < 1 || p > list_len) r.status = ST_RANGE;
        else r.value_out = list_mem[p-1];
      end
      default: begin
        // first match wins; zero when absent
        for (j = 0; j < list_len; j++) begin
          if (list_mem[j] == val && r.found_position == 0) r.found_position = 5'(j + 1);
        end
      end
    endcase
    r.count_out = list_len[4:0];
    return r;
  endfunction

  task automatic flag_fault(string why);
    fault_count++;
    if (fault_count <= 10) $display("%0t ns: %s", $time, why);
  endtask

  // ---------------------------------------------------------------------------
  // Monitor: sample both handshakes and the config port at the rising edge.
  // ---------------------------------------------------------------------------
  list_result_t seen_exp;

  always @(posedge clk) begin
    if (rst_n) begin
      // check the result word first, then predict the new request
      if (out_valid && !out_stall) begin
        if (expected_q.size() == 0) begin
          flag_fault($sformatf("result with nothing expected: st=%0d val=%h pos=%0d cnt=%0d",
                               out_status, out_value_out, out_found_position,
                               out_count_out));
        end else begin
          seen_exp = expected_q.pop_front();
          if (out_status !== seen_exp.status || out_value_out !== seen_exp.value_out ||
              out_found_position !== seen_exp.found_position ||
              out_count_out !== seen_exp.count_out) begin
            flag_fault($sformatf(
              "mismatch: exp st=%0d val=%h pos=%0d cnt=%0d / got st=%0d val=%h pos=%0d cnt=%0d",
              seen_exp.status, seen_exp.value_out, seen_exp.found_position,
              seen_exp.count_out, out_status, out_value_out, out_found_position,
              out_count_out));
          end
        end
      end
      if (in_valid && !in_stall) begin
        expected_q.push_back(apply_request(olids_act_t'(in_action), in_position, in_value));
        req_taken++;
      end
      if (cfg_we) cap_reg = cfg_wdata;
    end
  end

  // ---------------------------------------------------------------------------
  // Driver: offer queued words in bursts with random gaps; hold a word until
  // it is taken.
  // ---------------------------------------------------------------------------
  int        burst_left = 1;
  int        gap_left = 0;
  int        gap_pick;
  list_req_t drive_item;

  always @(negedge clk) begin
    if (rst_n) begin
      // slot is free when nothing is offered or the offered word was taken
      if (!in_valid || req_taken == req_offered) begin
        if (gap_left != 0) begin
          gap_left <= gap_left - 1;
          in_valid <= 1'b0;
        end else if (pending_q.size() != 0) begin
          drive_item = pending_q.pop_front();
          in_action <= drive_item.act;
          in_position <= drive_item.pos;
          in_value <= drive_item.val;
          in_valid <= 1'b1;
          req_offered <= req_offered + 1;
          if (burst_left <= 1) begin
            burst_left <= $urandom_range(1, 12);
            gap_pick = $urandom_range(0, 9);
            if (gap_pick < 4) gap_left <= 0;
            else if (gap_pick < 8) gap_left <= $urandom_range(1, 4);
            else gap_left <= $urandom_range(5, 30);
          end else begin
            burst_left <= burst_left - 1;
          end
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Receiver: stall in segments of random density, plus two long hold-offs
  // that back the block up until it stalls its input.
  // ---------------------------------------------------------------------------
  int seg_left = 0;
  int stall_pct = 0;
  int hold_left = 0;
  int holds_done = 0;

  always @(negedge clk) begin
    if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_stall <= 1'b1;
    end else if ((holds_done == 0 && req_taken >= HOLD_MARK_A) ||
                 (holds_done == 1 && req_taken >= HOLD_MARK_B)) begin
      holds_done <= holds_done + 1;
      hold_left <= HOLD_CYCLES;
      out_stall <= 1'b1;
    end else begin
      if (seg_left == 0) begin
        seg_left <= $urandom_range(5, 60);
        case ($urandom_range(0, 3))
          0: stall_pct <= 0;
          1: stall_pct <= 20;
          2: stall_pct <= 50;
          default: stall_pct <= 85;
        endcase
      end else begin
        seg_left <= seg_left - 1;
      end
      out_stall <= ($urandom_range(0, 99) < stall_pct);
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus generation. Track the list length as it will evolve so that most
  // positions land in range; keep recently inserted values for locate hits.
  // ---------------------------------------------------------------------------
  int          gen_count = 0;
  int          gen_lim = LIMIT_RESET;
  logic [31:0] value_pool [$];

  task automatic push_req(olids_act_t act, int pos, logic [31:0] val);
    list_req_t w;
    w.act = act;
    w.pos = pos[4:0];
    w.val = val;
    pending_q.push_back(w);
    req_pushed++;
    if (act == ACT_INSERT && w.pos >= 1 && w.pos <= gen_count + 1 && gen_count < gen_lim) begin
      gen_count++;
      value_pool.push_back(val);
      if (value_pool.size() > 12) void'(value_pool.pop_front());
    end else if (act == ACT_DELETE && w.pos >= 1 && w.pos <= gen_count) begin
      gen_count--;
    end
  endtask

  task automatic queue_random(int n);
    int k;
    int r;
    int p;
    olids_act_t a;
    logic [31:0] v;
    for (k = 0; k < n; k++) begin
      r = $urandom_range(0, 99);
      if (r < 35) a = ACT_INSERT;
      else if (r < 55) a = ACT_DELETE;
      else if (r < 75) a = ACT_GET;
      else a = ACT_LOCATE;
      // mostly valid positions, the rest anywhere in the field
      if ($urandom_range(0, 99) < 85) begin
        if (a == ACT_INSERT) p = $urandom_range(1, gen_count + 1);
        else if (gen_count > 0) p = $urandom_range(1, gen_count);
        else p = $urandom_range(0, 31);
      end else begin
        p = $urandom_range(0, 31);
      end
      r = $urandom_range(0, 99);
      if (r < 40 && value_pool.size() > 0) begin
        v = value_pool[$urandom_range(0, value_pool.size() - 1)];
      end else if (r < 48) begin
        case ($urandom_range(0, 3))
          0: v = 32'h0000_0000;
          1: v = 32'h7fff_ffff;
          2: v = 32'h8000_0000;
          default: v = 32'hffff_ffff;
        endcase
      end else begin
        v = $urandom;
      end
      push_req(a, p, v);
    end
  endtask

  // Wait until every queued word has gone in and every result has come out,
  // then let the block settle.
  task automatic drain_all();
    while (pending_q.size() != 0 || req_taken != req_pushed || expected_q.size() != 0)
      @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_cap(logic [4:0] lim);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= lim;
    @(negedge clk);
    cfg_we <= 1'b0;
    gen_lim = (lim > DEPTH) ? DEPTH : int'(lim);
  endtask

  initial begin
    int k;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed: empty-list refusals, edge values, first-match locate,
    // fill to the reset limit, then range-before-full.
    push_req(ACT_GET, 1, 32'd5);
    push_req(ACT_DELETE, 0, 32'd0);
    push_req(ACT_INSERT, 0, 32'd1);
    push_req(ACT_INSERT, 2, 32'd1);
    push_req(ACT_INSERT, 1, 32'h7fff_ffff);
    push_req(ACT_INSERT, 1, 32'h8000_0000);
    push_req(ACT_INSERT, 3, 32'hffff_ffff);
    push_req(ACT_INSERT, 2, 32'h0000_0000);
    push_req(ACT_LOCATE, 0, 32'h8000_0000);
    push_req(ACT_LOCATE, 0, 32'hffff_ffff);
    push_req(ACT_LOCATE, 31, 32'd12345);
    push_req(ACT_GET, 4, 32'd0);
    push_req(ACT_GET, 5, 32'd0);
    push_req(ACT_GET, 31, 32'd0);
    push_req(ACT_DELETE, 4, 32'd0);
    push_req(ACT_DELETE, 1, 32'd0);
    push_req(ACT_INSERT, 3, 32'h0000_0000);
    push_req(ACT_LOCATE, 0, 32'h0000_0000);
    for (k = 0; k < 7; k++) push_req(ACT_INSERT, 1, $urandom);
    push_req(ACT_INSERT, 12, 32'd7);
    push_req(ACT_INSERT, 1, 32'd7);
    drain_all();

    // Random phases over a spread of limits: full depth, lowered under the
    // current length, zero, saturating, one, and random picks.
    write_cap(5'd16);
    queue_random(PHASE_WORDS);
    drain_all();
    write_cap(5'd3);
    queue_random(PHASE_WORDS);
    drain_all();
    write_cap(5'd0);
    queue_random(PHASE_WORDS);
    drain_all();
    write_cap(5'd31);
    queue_random(PHASE_WORDS);
    drain_all();
    write_cap(5'd1);
    queue_random(PHASE_WORDS);
    drain_all();
    write_cap(5'($urandom_range(2, 15)));
    queue_random(PHASE_WORDS);
    drain_all();
    write_cap(5'd16);
    queue_random(PHASE_WORDS);
    drain_all();
    write_cap(5'($urandom_range(0, 31)));
    queue_random(PHASE_WORDS);
    drain_all();

    if (fault_count == 0) begin
      $display("ordered_list_insert_delete_search_tb: PASS");
    end else begin
      $display("ordered_list_insert_delete_search_tb: FAIL");
    end
    $finish;
  end

  // Hard stop well beyond the slowest correct run.
  initial begin
    #2000000;
    $display("ordered_list_insert_delete_search_tb: FAIL");
    $finish;
  end

endmodule

[filelist.f]
src/olids_pkg.sv
src/olids_store.sv
src/olids_seq.sv
src/ordered_list_insert_delete_search.sv
test/ordered_list_insert_delete_search_tb.sv
